// ===== design/sbpe_pkg.sv =====
// Package for the serial boot programming engine.
// Holds widths, request kinds, parse phases and the result word type.
// No dependencies.
package sbpe_pkg;

  localparam int unsigned DefPageBytes = 128;
  localparam int unsigned MaxRes = 7;
  localparam int unsigned CntW = 3;

  typedef enum logic [3:0] {
    K_SEND = 4'd0, K_FILL = 4'd1, K_PWRITE = 4'd2, K_PERASE = 4'd3,
    K_EEWRITE = 4'd4, K_FREAD = 4'd5, K_EEREAD = 4'd6, K_LOCKW = 4'd7,
    K_FUSER = 4'd8, K_EXIT = 4'd9
  } kind_t;

  localparam logic [1:0] F_HOST = 2'd0;
  localparam logic [1:0] F_MEM = 2'd1;
  localparam logic [1:0] F_DONE = 2'd2;

  localparam logic [1:0] REG_BOOT = 2'd0;
  localparam logic [1:0] REG_PART = 2'd1;
  localparam logic [1:0] REG_SIG = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_A_HI, PH_A_LO, PH_C_LOW, PH_C_HIGH, PH_D_ARG, PH_L_ARG,
    PH_SKIP_ARG, PH_B_HI, PH_B_LO, PH_B_MEM, PH_G_HI, PH_G_LO, PH_G_MEM,
    PH_WR_FLASH, PH_WR_EEP, PH_RD_FLASH, PH_RD_EEP, PH_ERASE, PH_R_HIGH,
    PH_R_LOW, PH_D_READ, PH_FUSE_READ
  } phase_t;

  // One result word.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  tx_byte;
    logic [16:0] mem_address;
    logic [15:0] mem_value;
  } res_t;

  // A batch of result words caused by one input word.
  typedef struct packed {
    logic [CntW-1:0]       count;
    res_t [MaxRes-1:0]     res;
  } batch_t;

  function automatic res_t mk(input kind_t k, input logic [7:0] tx,
                              input logic [16:0] a, input logic [15:0] v);
    res_t r;
    r.kind = k;
    r.tx_byte = tx;
    r.mem_address = a;
    r.mem_value = v;
    return r;
  endfunction

  function automatic res_t say(input logic [7:0] b);
    return mk(K_SEND, b, 17'd0, 16'd0);
  endfunction

endpackage

// ===== design/sbpe_parser.sv =====
// Command parser: computes the result batch and next protocol state.
// Depends on sbpe_pkg.
module sbpe_parser import sbpe_pkg::*; #(
  parameter int unsigned PAGE_BYTES = DefPageBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  mem_data,
  input  logic [17:0] boot_area_start,
  input  logic [7:0]  part_code,
  input  logic [23:0] signature,
  output batch_t      batch
);

  localparam logic [17:0] PageStep = 18'(PAGE_BYTES);
  localparam logic [7:0] PageHi = 8'((PAGE_BYTES >> 8) & 255);
  localparam logic [7:0] PageLo = 8'(PAGE_BYTES & 255);

  phase_t      phase, phase_next;
  logic [15:0] word_address, word_address_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [15:0] block_remaining, block_remaining_next;
  logic        block_is_flash, block_is_flash_next;
  logic [16:0] erase_pointer, erase_pointer_next;
  logic        word_half, word_half_next;

  logic [16:0] baddr, waddr_ext;
  logic [15:0] waddr_inc, rem_dec, rem_round;
  logic [17:0] prot_limit, erase_nxt;
  logic [7:0]  b;

  assign b = rx_byte;
  assign baddr = {word_address, 1'b0};
  assign waddr_ext = {1'b0, word_address};
  assign waddr_inc = word_address + 16'd1;
  assign rem_dec = block_remaining - 16'd1;
  assign rem_round = 16'(({1'b0, block_remaining} + 17'd1) >> 1);
  assign prot_limit = (boot_area_start == 18'd0) ? 18'd0 : ((boot_area_start - 18'd1) >> 1);
  assign erase_nxt = {1'b0, erase_pointer} + PageStep;

  // Next state and result batch for one input word.
  always_comb begin
    logic [15:0] rem;
    phase_next = phase;
    word_address_next = word_address;
    low_byte_hold_next = low_byte_hold;
    block_remaining_next = block_remaining;
    block_is_flash_next = block_is_flash;
    erase_pointer_next = erase_pointer;
    word_half_next = word_half;
    batch.count = '0;
    batch.res = '0;
    rem = rem_round;
    if (func == F_HOST) begin
      phase_next = PH_IDLE;
      case (phase)
        PH_IDLE: begin
          case (b)
            "a": begin batch.res[0] = say("Y"); batch.count = 3'd1; end
            "A": phase_next = PH_A_HI;
            "e": begin
              if (boot_area_start > 18'd1) begin
                erase_pointer_next = '0;
                batch.res[0] = mk(K_PERASE, 8'd0, 17'd0, 16'd0);
                phase_next = PH_ERASE;
              end else begin
                batch.res[0] = say(8'h0d);
              end
              batch.count = 3'd1;
            end
            "b": begin
              batch.res[0] = say("Y"); batch.res[1] = say(PageHi);
              batch.res[2] = say(PageLo); batch.count = 3'd3;
            end
            "B": phase_next = PH_B_HI;
            "g": phase_next = PH_G_HI;
            "R": begin
              batch.res[0] = mk(K_FREAD, 8'd0, baddr + 17'd1, 16'd0);
              batch.count = 3'd1; phase_next = PH_R_HIGH;
            end
            "c": phase_next = PH_C_LOW;
            "C": phase_next = PH_C_HIGH;
            "m": begin
              if ({2'b0, word_address} >= prot_limit) batch.res[0] = say("?");
              else batch.res[0] = mk(K_PWRITE, 8'd0, baddr, 16'd0);
              batch.res[1] = say(8'h0d); batch.count = 3'd2;
            end
            "D": phase_next = PH_D_ARG;
            "d": begin
              batch.res[0] = mk(K_EEREAD, 8'd0, waddr_ext, 16'd0);
              batch.count = 3'd1; phase_next = PH_D_READ;
            end
            "l": phase_next = PH_L_ARG;
            "r", "F", "N", "Q": begin
              batch.res[0] = mk(K_FUSER, 8'd0,
                (b == "r") ? 17'd0 : (b == "F") ? 17'd1 : (b == "N") ? 17'd2 : 17'd3,
                16'd0);
              batch.count = 3'd1; phase_next = PH_FUSE_READ;
            end
            "P", "L": begin batch.res[0] = say(8'h0d); batch.count = 3'd1; end
            "E": begin
              batch.res[0] = say(8'h0d);
              batch.res[1] = mk(K_EXIT, 8'd0, 17'd0, 16'd0); batch.count = 3'd2;
            end
            "p": begin batch.res[0] = say("S"); batch.count = 3'd1; end
            "t": begin
              batch.res[0] = say(part_code); batch.res[1] = say(8'd0);
              batch.count = 3'd2;
            end
            "x", "y", "T": phase_next = PH_SKIP_ARG;
            "S": begin
              batch.res[0] = say("A"); batch.res[1] = say("V");
              batch.res[2] = say("R"); batch.res[3] = say("B");
              batch.res[4] = say("O"); batch.res[5] = say("O");
              batch.res[6] = say("T"); batch.count = 3'd7;
            end
            "V": begin
              batch.res[0] = say("1"); batch.res[1] = say("5"); batch.count = 3'd2;
            end
            "s": begin
              batch.res[0] = say(signature[23:16]); batch.res[1] = say(signature[15:8]);
              batch.res[2] = say(signature[7:0]); batch.count = 3'd3;
            end
            8'h1b: ;
            default: begin batch.res[0] = say("?"); batch.count = 3'd1; end
          endcase
        end
        PH_A_HI: begin word_address_next = {b, 8'd0}; phase_next = PH_A_LO; end
        PH_A_LO: begin
          word_address_next = {word_address[15:8], b};
          batch.res[0] = say(8'h0d); batch.count = 3'd1;
        end
        PH_C_LOW: begin
          low_byte_hold_next = b; batch.res[0] = say(8'h0d); batch.count = 3'd1;
        end
        PH_C_HIGH: begin
          batch.res[0] = mk(K_FILL, 8'd0, baddr, {b, low_byte_hold});
          batch.res[1] = say(8'h0d); batch.count = 3'd2;
          word_address_next = waddr_inc;
        end
        PH_D_ARG: begin
          batch.res[0] = mk(K_EEWRITE, 8'd0, waddr_ext, {8'd0, b});
          batch.res[1] = say(8'h0d); batch.count = 3'd2;
          word_address_next = waddr_inc;
        end
        PH_L_ARG: begin
          batch.res[0] = mk(K_LOCKW, 8'd0, 17'd0, {8'd0, ~b});
          batch.res[1] = say(8'h0d); batch.count = 3'd2;
        end
        PH_SKIP_ARG: begin batch.res[0] = say(8'h0d); batch.count = 3'd1; end
        PH_B_HI, PH_G_HI: begin
          block_remaining_next = {b, 8'd0};
          phase_next = (phase == PH_B_HI) ? PH_B_LO : PH_G_LO;
        end
        PH_B_LO, PH_G_LO: begin
          block_remaining_next = {block_remaining[15:8], b};
          phase_next = (phase == PH_B_LO) ? PH_B_MEM : PH_G_MEM;
        end
        PH_B_MEM: begin
          if (b == "F" || b == "E") begin
            block_is_flash_next = (b == "F");
            if (b != "F") rem = block_remaining;
            block_remaining_next = rem;
            if (rem == 16'd0) begin
              batch.res[0] = say(8'h0d); batch.count = 3'd1;
            end else begin
              erase_pointer_next = baddr;
              word_half_next = 1'b0;
              phase_next = (b == "F") ? PH_WR_FLASH : PH_WR_EEP;
            end
          end else begin
            batch.res[0] = say("?"); batch.count = 3'd1;
          end
        end
        PH_G_MEM: begin
          if (b == "F" || b == "E") begin
            block_is_flash_next = (b == "F");
            if (b != "F") rem = block_remaining;
            block_remaining_next = rem;
            if (rem != 16'd0) begin
              word_half_next = 1'b0;
              batch.count = 3'd1;
              if (b == "F") begin
                batch.res[0] = mk(K_FREAD, 8'd0, baddr, 16'd0);
                phase_next = PH_RD_FLASH;
              end else begin
                batch.res[0] = mk(K_EEREAD, 8'd0, waddr_ext, 16'd0);
                phase_next = PH_RD_EEP;
              end
            end
          end
        end
        PH_WR_FLASH: begin
          phase_next = PH_WR_FLASH;
          if (!word_half) begin
            low_byte_hold_next = b; word_half_next = 1'b1;
          end else begin
            word_half_next = 1'b0;
            batch.res[0] = mk(K_FILL, 8'd0, baddr, {b, low_byte_hold});
            batch.count = 3'd1;
            word_address_next = waddr_inc;
            block_remaining_next = rem_dec;
            if (rem_dec == 16'd0) begin
              batch.res[1] = mk(K_PWRITE, 8'd0, erase_pointer, 16'd0);
              batch.res[2] = say(8'h0d); batch.count = 3'd3;
              phase_next = PH_IDLE;
            end
          end
        end
        PH_WR_EEP: begin
          batch.res[0] = mk(K_EEWRITE, 8'd0, waddr_ext, {8'd0, b});
          batch.count = 3'd1;
          word_address_next = waddr_inc;
          block_remaining_next = rem_dec;
          if (rem_dec == 16'd0) begin
            batch.res[1] = say(8'h0d); batch.count = 3'd2;
          end else begin
            phase_next = PH_WR_EEP;
          end
        end
        default: phase_next = phase;
      endcase
    end else if (func == F_MEM) begin
      case (phase)
        PH_RD_FLASH: begin
          batch.res[0] = say(mem_data); batch.count = 3'd1;
          if (!word_half) begin
            word_half_next = 1'b1;
            batch.res[1] = mk(K_FREAD, 8'd0, baddr + 17'd1, 16'd0);
            batch.count = 3'd2;
          end else begin
            word_half_next = 1'b0;
            word_address_next = waddr_inc;
            block_remaining_next = rem_dec;
            if (rem_dec != 16'd0) begin
              batch.res[1] = mk(K_FREAD, 8'd0, {waddr_inc, 1'b0}, 16'd0);
              batch.count = 3'd2;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_RD_EEP: begin
          batch.res[0] = say(mem_data); batch.count = 3'd1;
          word_address_next = waddr_inc;
          block_remaining_next = rem_dec;
          if (rem_dec != 16'd0) begin
            batch.res[1] = mk(K_EEREAD, 8'd0, {1'b0, waddr_inc}, 16'd0);
            batch.count = 3'd2;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_R_HIGH: begin
          batch.res[0] = say(mem_data);
          batch.res[1] = mk(K_FREAD, 8'd0, baddr, 16'd0);
          batch.count = 3'd2; phase_next = PH_R_LOW;
        end
        PH_R_LOW, PH_D_READ: begin
          batch.res[0] = say(mem_data); batch.count = 3'd1;
          word_address_next = waddr_inc; phase_next = PH_IDLE;
        end
        PH_FUSE_READ: begin
          batch.res[0] = say(mem_data); batch.count = 3'd1; phase_next = PH_IDLE;
        end
        default: ;
      endcase
    end else if (func == F_DONE) begin
      if (phase == PH_ERASE) begin
        batch.count = 3'd1;
        if (!erase_nxt[17] && (erase_nxt + 18'd1 < boot_area_start)) begin
          erase_pointer_next = erase_nxt[16:0];
          batch.res[0] = mk(K_PERASE, 8'd0, erase_nxt[16:0], 16'd0);
        end else begin
          phase_next = PH_IDLE;
          batch.res[0] = say(8'h0d);
        end
      end
    end
  end

  // Protocol state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      word_address <= '0;
      low_byte_hold <= '0;
      block_remaining <= '0;
      block_is_flash <= 1'b0;
      erase_pointer <= '0;
      word_half <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      word_address <= word_address_next;
      low_byte_hold <= low_byte_hold_next;
      block_remaining <= block_remaining_next;
      block_is_flash <= block_is_flash_next;
      erase_pointer <= erase_pointer_next;
      word_half <= word_half_next;
    end
  end

  // The erase pointer stays inside the 17-bit address space while erasing.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERASE) |-> (erase_pointer < 17'h1FFFF))
    else $error("erase pointer overran address space");
  // Block states never start with nothing to move.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WR_EEP || phase == PH_RD_EEP) |-> (block_remaining != 16'd0))
    else $error("eeprom block running with zero count");
  assert property (@(posedge clk) disable iff (rst)
    $past(step) && $past(func) == F_HOST && $past(phase) == PH_A_HI |-> phase == PH_A_LO)
    else $error("address argument sequence broken");
  // Flash block phases always carry the flash memory type.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WR_FLASH || phase == PH_RD_FLASH) |-> block_is_flash)
    else $error("flash block phase without flash memory type");

endmodule

// ===== design/sbpe_out_queue.sv =====
// Output stage: holds one result batch and sends its words one per cycle while not stalled.
// Depends on sbpe_pkg.
module sbpe_out_queue import sbpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  batch_t      batch_in,
  output logic        busy,
  output logic        valid,
  input  logic        stall,
  output res_t        head,
  output logic        last
);

  res_t [MaxRes-1:0] store;
  logic [CntW-1:0]   count, pos;

  assign busy = (count != '0);
  assign valid = busy;
  assign head = store[pos];
  assign last = (pos == count - 3'd1);

  // Batch storage; a new batch loads only when the stage is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos <= '0;
    end else if (load) begin
      count <= batch_in.count;
      pos <= '0;
    end else if (valid && !stall) begin
      if (last) begin
        count <= '0;
        pos <= '0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) store <= batch_in.res;
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> pos < count)
    else $error("result pointer beyond batch");
  assert property (@(posedge clk) disable iff (rst) count <= 3'(MaxRes))
    else $error("batch too long");

endmodule

// ===== design/serial_boot_programming_engine.sv =====
// Top level of the serial boot programming engine.
// Depends on sbpe_pkg, sbpe_parser and sbpe_out_queue.
//
// Input words (func, rx_byte, mem_data) arrive on the valid/stall channel:
// func 0 is a host byte, 1 a byte read back from memory, 2 a memory-done
// acknowledgement. Each word gives zero to seven result words (kind, tx_byte,
// mem_address, mem_value, last) on the output channel; last marks the final
// result word of a batch. Configuration registers are to be written through
// cfg_we/cfg_index/cfg_data while the block is idle; the user must keep to
// this, as the block does not enforce it. The parser state updates in the
// cycle a word is accepted and its batch is registered; the first result
// word is offered the next cycle, then one word per cycle while the receiver
// does not stall. The next word is taken in the cycle the last result leaves
// (or at once if the stage is empty), so no word is taken while a batch still
// has other words to send. While the receiver stalls, the current result holds
// and input is stalled once the stage is full. Reset clears the protocol state
// to idle, word address to zero, and loads the register reset values.
module serial_boot_programming_engine import sbpe_pkg::*; #(
  parameter int unsigned PAGE_BYTES = DefPageBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [16:0] mem_address,
  output logic [15:0] mem_value,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [17:0] boot_area_start;
  logic [7:0]  part_code;
  logic [23:0] signature;
  logic        step, busy, q_last;
  batch_t      batch;
  res_t        head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_area_start <= 18'd28672;
      part_code <= '0;
      signature <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOOT: boot_area_start <= cfg_data[17:0];
        REG_PART: part_code <= cfg_data[7:0];
        REG_SIG:  signature <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept when the output stage is empty or its final word leaves now.
  assign in_stall = busy && !(q_last && !out_stall);
  assign step = in_valid && !in_stall;

  sbpe_parser #(.PAGE_BYTES(PAGE_BYTES)) u_parser (
    .clk, .rst, .step, .func, .rx_byte, .mem_data,
    .boot_area_start, .part_code, .signature, .batch
  );

  sbpe_out_queue u_queue (
    .clk, .rst, .load(step), .batch_in(batch), .busy, .valid(out_valid),
    .stall(out_stall), .head, .last(q_last)
  );

  assign kind = head.kind;
  assign tx_byte = head.tx_byte;
  assign mem_address = head.mem_address;
  assign mem_value = head.mem_value;
  assign last = q_last;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall || q_last)
    else $error("input taken while batch not finished");

endmodule

// ===== tb/sv/sbpe_checker.sv =====
`timescale 1ns / 100ps
// Checker for the serial boot programming engine: watches the input, output and
// register ports, predicts every result word and compares. Depends on sbpe_pkg.
module sbpe_checker import sbpe_pkg::*; #(
  parameter int unsigned PAGE_BYTES = DefPageBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  mem_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  kind,
  input  logic [7:0]  tx_byte,
  input  logic [16:0] mem_address,
  input  logic [15:0] mem_value,
  input  logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          pending,
  output int          errors
);

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_QM = "?";
  localparam logic [7:0] CH_ESC = 8'h1b;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  tx;
    logic [16:0] addr;
    logic [15:0] val;
    logic        last;
  } reply_t;

  reply_t reply_q[$];

  // Mirror of the engine's registers and protocol state.
  logic [17:0] boot_start;
  logic [7:0]  dev_code;
  logic [23:0] sig_bytes;
  phase_t      phase;
  logic [15:0] waddr;
  logic [7:0]  low_hold;
  logic [15:0] remaining;
  logic        is_flash;
  logic [16:0] erase_ptr;
  logic        half;

  initial begin
    pending = 0;
    errors = 0;
  end

  function automatic logic [16:0] byte_at();
    return {waddr, 1'b0};
  endfunction

  task automatic put(input kind_t k, input logic [7:0] tx, input logic [16:0] a,
                     input logic [15:0] v);
    reply_t r;
    r.kind = k;
    r.tx = tx;
    r.addr = a;
    r.val = v;
    r.last = 1'b0;
    reply_q.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    put(K_SEND, b, 17'd0, 16'd0);
  endtask

  // Command decode from the idle phase.
  task automatic decode_command(input logic [7:0] b);
    logic [17:0] lim;
    case (b)
      "a": send_byte("Y");
      "A": phase = PH_A_HI;
      "e": begin
        if (boot_start > 18'd1) begin
          erase_ptr = '0;
          put(K_PERASE, 8'd0, 17'd0, 16'd0);
          phase = PH_ERASE;
        end else begin
          send_byte(CH_CR);
        end
      end
      "b": begin
        send_byte("Y");
        send_byte(8'((PAGE_BYTES >> 8) & 'hff));
        send_byte(8'(PAGE_BYTES & 'hff));
      end
      "B": phase = PH_B_HI;
      "g": phase = PH_G_HI;
      "R": begin
        put(K_FREAD, 8'd0, byte_at() + 17'd1, 16'd0);
        phase = PH_R_HIGH;
      end
      "c": phase = PH_C_LOW;
      "C": phase = PH_C_HIGH;
      "m": begin
        lim = (boot_start == 18'd0) ? 18'd0 : (boot_start - 18'd1) >> 1;
        if ({2'b00, waddr} >= lim) send_byte(CH_QM);
        else put(K_PWRITE, 8'd0, byte_at(), 16'd0);
        send_byte(CH_CR);
      end
      "D": phase = PH_D_ARG;
      "d": begin
        put(K_EEREAD, 8'd0, {1'b0, waddr}, 16'd0);
        phase = PH_D_READ;
      end
      "l": phase = PH_L_ARG;
      "r", "F", "N", "Q": begin
        put(K_FUSER, 8'd0, (b == "r") ? 17'd0 : (b == "F") ? 17'd1 :
            (b == "N") ? 17'd2 : 17'd3, 16'd0);
        phase = PH_FUSE_READ;
      end
      "P", "L": send_byte(CH_CR);
      "E": begin
        send_byte(CH_CR);
        put(K_EXIT, 8'd0, 17'd0, 16'd0);
      end
      "p": send_byte("S");
      "t": begin
        send_byte(dev_code);
        send_byte(8'd0);
      end
      "x", "y", "T": phase = PH_SKIP_ARG;
      "S": begin
        send_byte("A"); send_byte("V"); send_byte("R"); send_byte("B");
        send_byte("O"); send_byte("O"); send_byte("T");
      end
      "V": begin
        send_byte("1");
        send_byte("5");
      end
      "s": begin
        send_byte(sig_bytes[23:16]);
        send_byte(sig_bytes[15:8]);
        send_byte(sig_bytes[7:0]);
      end
      CH_ESC: ;
      default: send_byte(CH_QM);
    endcase
  endtask

  // Rounds a flash block size up to whole words.
  task automatic take_mem_type(input logic [7:0] b);
    logic [16:0] t;
    is_flash = (b == "F");
    if (is_flash) begin
      t = ({1'b0, remaining} + 17'd1) >> 1;
      remaining = t[15:0];
    end
  endtask

  task automatic host_word(input logic [7:0] b);
    phase_t p;
    p = phase;
    phase = PH_IDLE;
    case (p)
      PH_IDLE: decode_command(b);
      PH_A_HI: begin
        waddr = {b, 8'd0};
        phase = PH_A_LO;
      end
      PH_A_LO: begin
        waddr[7:0] = b;
        send_byte(CH_CR);
      end
      PH_C_LOW: begin
        low_hold = b;
        send_byte(CH_CR);
      end
      PH_C_HIGH: begin
        put(K_FILL, 8'd0, byte_at(), {b, low_hold});
        waddr = waddr + 16'd1;
        send_byte(CH_CR);
      end
      PH_D_ARG: begin
        put(K_EEWRITE, 8'd0, {1'b0, waddr}, {8'd0, b});
        waddr = waddr + 16'd1;
        send_byte(CH_CR);
      end
      PH_L_ARG: begin
        put(K_LOCKW, 8'd0, 17'd0, {8'd0, ~b});
        send_byte(CH_CR);
      end
      PH_SKIP_ARG: send_byte(CH_CR);
      PH_B_HI, PH_G_HI: begin
        remaining = {b, 8'd0};
        phase = phase_t'(p + 5'd1);
      end
      PH_B_LO, PH_G_LO: begin
        remaining[7:0] = b;
        phase = phase_t'(p + 5'd1);
      end
      PH_B_MEM: begin
        if (b == "F" || b == "E") begin
          take_mem_type(b);
          if (remaining == 16'd0) begin
            send_byte(CH_CR);
          end else begin
            erase_ptr = byte_at();
            half = 1'b0;
            phase = is_flash ? PH_WR_FLASH : PH_WR_EEP;
          end
        end else begin
          send_byte(CH_QM);
        end
      end
      PH_G_MEM: begin
        if (b == "F" || b == "E") begin
          take_mem_type(b);
          if (remaining != 16'd0) begin
            half = 1'b0;
            if (is_flash) begin
              put(K_FREAD, 8'd0, byte_at(), 16'd0);
              phase = PH_RD_FLASH;
            end else begin
              put(K_EEREAD, 8'd0, {1'b0, waddr}, 16'd0);
              phase = PH_RD_EEP;
            end
          end
        end
      end
      PH_WR_FLASH: begin
        phase = PH_WR_FLASH;
        if (!half) begin
          low_hold = b;
          half = 1'b1;
        end else begin
          half = 1'b0;
          put(K_FILL, 8'd0, byte_at(), {b, low_hold});
          waddr = waddr + 16'd1;
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            put(K_PWRITE, 8'd0, erase_ptr, 16'd0);
            send_byte(CH_CR);
            phase = PH_IDLE;
          end
        end
      end
      PH_WR_EEP: begin
        put(K_EEWRITE, 8'd0, {1'b0, waddr}, {8'd0, b});
        waddr = waddr + 16'd1;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) send_byte(CH_CR);
        else phase = PH_WR_EEP;
      end
      // Waiting on memory: the host byte is dropped.
      default: phase = p;
    endcase
  endtask

  task automatic mem_word(input logic [7:0] d);
    case (phase)
      PH_RD_FLASH: begin
        send_byte(d);
        if (!half) begin
          half = 1'b1;
          put(K_FREAD, 8'd0, byte_at() + 17'd1, 16'd0);
        end else begin
          half = 1'b0;
          waddr = waddr + 16'd1;
          remaining = remaining - 16'd1;
          if (remaining != 16'd0) put(K_FREAD, 8'd0, byte_at(), 16'd0);
          else phase = PH_IDLE;
        end
      end
      PH_RD_EEP: begin
        send_byte(d);
        waddr = waddr + 16'd1;
        remaining = remaining - 16'd1;
        if (remaining != 16'd0) put(K_EEREAD, 8'd0, {1'b0, waddr}, 16'd0);
        else phase = PH_IDLE;
      end
      PH_R_HIGH: begin
        send_byte(d);
        put(K_FREAD, 8'd0, byte_at(), 16'd0);
        phase = PH_R_LOW;
      end
      PH_R_LOW, PH_D_READ: begin
        send_byte(d);
        waddr = waddr + 16'd1;
        phase = PH_IDLE;
      end
      PH_FUSE_READ: begin
        send_byte(d);
        phase = PH_IDLE;
      end
      default: ;
    endcase
  endtask

  // Chip erase moves one page per acknowledgement until the boot area.
  task automatic done_word();
    int nxt;
    if (phase == PH_ERASE) begin
      nxt = int'(erase_ptr) + int'(PAGE_BYTES);
      if (nxt <= 'h1ffff && nxt + 1 < int'(boot_start)) begin
        erase_ptr = 17'(nxt);
        put(K_PERASE, 8'd0, 17'(nxt), 16'd0);
      end else begin
        phase = PH_IDLE;
        send_byte(CH_CR);
      end
    end
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    int size_at_entry;
    reply_t r;
    if (rst) begin
      boot_start = 18'd28672;
      dev_code = '0;
      sig_bytes = '0;
      phase = PH_IDLE;
      waddr = '0;
      low_hold = '0;
      remaining = '0;
      is_flash = 1'b0;
      erase_ptr = '0;
      half = 1'b0;
      reply_q.delete();
    end else begin
      // Result words leaving the block.
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("result word with no expectation: kind %0d tx 'h%0h", kind, tx_byte);
          errors++;
        end else begin
          r = reply_q.pop_front();
          compare_field("kind", r.kind, kind);
          compare_field("tx_byte", r.tx, tx_byte);
          compare_field("mem_address", r.addr, mem_address);
          compare_field("mem_value", r.val, mem_value);
          compare_field("last", r.last, last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_BOOT) boot_start = cfg_data[17:0];
        else if (cfg_index == REG_PART) dev_code = cfg_data[7:0];
        else if (cfg_index == REG_SIG) sig_bytes = cfg_data;
      end
      // Input words entering the block.
      if (in_valid && !in_stall) begin
        size_at_entry = reply_q.size();
        case (func)
          F_HOST: host_word(rx_byte);
          F_MEM: mem_word(mem_data);
          F_DONE: done_word();
          default: ;
        endcase
        if (reply_q.size() > size_at_entry) reply_q[reply_q.size() - 1].last = 1'b1;
      end
    end
    pending <= reply_q.size();
  end

endmodule

// ===== tb/sv/tb_serial_boot_programming_engine.sv =====
`timescale 1ns / 100ps
// Testbench top for the serial boot programming engine: drives protocol sequences
// under several flow-control phases. Depends on sbpe_pkg and sbpe_checker.
module tb_serial_boot_programming_engine;
  import sbpe_pkg::*;

  localparam int CycleLimit = 800000;
  localparam logic [7:0] CH_ESC = 8'h1b;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = F_HOST;
  logic [7:0]  rx_byte = 8'd0;
  logic [7:0]  mem_data = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  kind;
  logic [7:0]  tx_byte;
  logic [16:0] mem_address;
  logic [15:0] mem_value;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BOOT;
  logic [23:0] cfg_data = 24'd0;

  int pending;
  int errors;
  int gap_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int cfg_writes = 0;
  int cycles = 0;
  logic [17:0] cur_boot = 18'd28672;

  serial_boot_programming_engine u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .rx_byte(rx_byte), .mem_data(mem_data), .out_valid(out_valid),
    .out_stall(out_stall), .kind(kind), .tx_byte(tx_byte),
    .mem_address(mem_address), .mem_value(mem_value), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sbpe_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .rx_byte(rx_byte), .mem_data(mem_data), .out_valid(out_valid),
    .out_stall(out_stall), .kind(kind), .tx_byte(tx_byte),
    .mem_address(mem_address), .mem_value(mem_value), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offers one word and holds it until accepted.
  task automatic drive_word(input logic [1:0] f, input logic [7:0] rx, input logic [7:0] md);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= rx;
    mem_data <= md;
    do @(posedge clk); while (in_stall);
    if (f != 2'd3) words_sent++;
  endtask

  task automatic host(input logic [7:0] b);
    drive_word(F_HOST, b, 8'($urandom));
  endtask

  task automatic mem(input logic [7:0] d);
    drive_word(F_MEM, 8'($urandom), d);
  endtask

  task automatic ack();
    drive_word(F_DONE, 8'($urandom), 8'($urandom));
  endtask

  // Waits until every result has left, then lets the pipeline settle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    if (idx == REG_BOOT) cur_boot = val[17:0];
  endtask

  function automatic int erase_pages(input logic [17:0] bound);
    int n;
    n = 0;
    for (int p = 0; p <= 'h1ffff && p + 1 < int'(bound); p += DefPageBytes) n++;
    return n;
  endfunction

  task automatic chip_erase();
    int n;
    n = erase_pages(cur_boot);
    host("e");
    repeat (n) ack();
  endtask

  task automatic load_block(input logic [15:0] size, input logic [7:0] mtype);
    int n;
    host("B");
    host(size[15:8]);
    host(size[7:0]);
    host(mtype);
    n = 0;
    if (mtype == "F") n = 2 * ((int'(size) + 1) / 2);
    else if (mtype == "E") n = size;
    repeat (n) host(8'($urandom));
  endtask

  task automatic fetch_block(input logic [15:0] size, input logic [7:0] mtype);
    int n;
    host("g");
    host(size[15:8]);
    host(size[7:0]);
    host(mtype);
    n = 0;
    if (mtype == "F") n = 2 * ((int'(size) + 1) / 2);
    else if (mtype == "E") n = size;
    repeat (n) mem(8'($urandom));
  endtask

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(9);
    if (r < 5) return "F";
    if (r < 9) return "E";
    return 8'($urandom);
  endfunction

  // One random command sequence, mostly well formed.
  task automatic random_sequence();
    logic [7:0] c;
    case ($urandom_range(0, 27))
      0: host("a");
      1, 2: begin
        host("A");
        host(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)));
        host(8'($urandom));
      end
      3: if (erase_pages(cur_boot) <= 40) chip_erase(); else host("b");
      4: host("b");
      5, 6: load_block(16'($urandom_range(0, 9)), pick_type());
      7, 8: fetch_block(16'($urandom_range(0, 9)), pick_type());
      9: begin
        host("R");
        mem(8'($urandom));
        mem(8'($urandom));
      end
      10: begin
        host("c");
        host(8'($urandom));
      end
      11: begin
        host("C");
        host(8'($urandom));
      end
      12: host("m");
      13: begin
        host("D");
        host(8'($urandom));
      end
      14: begin
        host("d");
        mem(8'($urandom));
      end
      15: begin
        host("l");
        host(8'($urandom));
      end
      16: begin
        case ($urandom_range(3))
          0: c = "r";
          1: c = "F";
          2: c = "N";
          default: c = "Q";
        endcase
        host(c);
        mem(8'($urandom));
      end
      17: host(($urandom_range(1) == 0) ? 8'("P") : 8'("L"));
      18: host("E");
      19: host("p");
      20: host("t");
      21: begin
        case ($urandom_range(2))
          0: c = "x";
          1: c = "y";
          default: c = "T";
        endcase
        host(c);
        host(8'($urandom));
      end
      22: host("S");
      23: host("V");
      24: host("s");
      25: host(CH_ESC);
      26: host(8'($urandom));
      // Noise and broken sequences: any word kind with random content.
      default: begin
        repeat ($urandom_range(1, 3))
          drive_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
    endcase
  endtask

  initial begin
    int target;
    logic [17:0] boots[4];
    boots[0] = 18'd256;
    boots[1] = 18'd0;
    boots[2] = 18'd131072;
    boots[3] = 18'd2;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with reset register values.
    host("a"); host("b"); host("S"); host("V"); host("p"); host("t"); host("s");
    host(CH_ESC); host("z");
    // Address wrap past the top word.
    host("A"); host(8'hff); host(8'hff);
    host("c"); host(8'h00); host("C"); host(8'hff);
    host("m");
    host("R"); mem(8'hff); mem(8'h00);
    load_block(16'd0, "F");
    load_block(16'd3, "F");
    fetch_block(16'd1, "E");
    load_block(16'd1, "X");
    drive_word(2'd3, 8'hff, 8'hff);
    ack();
    host("l"); host(8'h00);
    host("E");

    // Random phases, one register setting and one flow-control style each.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_BOOT, {6'd0, boots[ph]});
      write_reg(REG_PART, (ph == 0) ? 24'hff : (ph == 1) ? 24'h0 : 24'($urandom_range(255)));
      write_reg(REG_SIG, (ph == 0) ? 24'hffffff : (ph == 1) ? 24'h0 : 24'($urandom));
      case (ph)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 61; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 61; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      if (erase_pages(cur_boot) <= 40) chip_erase();
      target = words_sent + 65;
      while (words_sent < target) random_sequence();
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Drove %0d words through four flow-control phases with %0d register writes.",
             words_sent, cfg_writes);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
